/* sv/bellman_ford_csr_shortest_paths_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the shortest paths unit
// Shared forms of the concurrent checks used by the unit's checker.
// ----------------------------------------------------------------------------
`ifndef BELLMAN_FORD_CSR_SHORTEST_PATHS_UNIT_ASSERT_SVH
`define BELLMAN_FORD_CSR_SHORTEST_PATHS_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFSP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bfsp check failed");

// The consequent must hold in the cycle after the antecedent.
`define BFSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bfsp check failed");

`endif

/* sv/bfsp_pkg.sv */
// ----------------------------------------------------------------------------
// Shortest paths unit package
// Field widths, codes and default sizes shared by the unit and its checker.
// ----------------------------------------------------------------------------
package bfsp_pkg;

   localparam int MAX_VERTICES_DEFAULT = 256;
   localparam int MAX_EDGES_DEFAULT    = 1024;
   localparam int WEIGHT_BITS_DEFAULT  = 32;

   localparam int OFFSET_BITS = 11;
   localparam int TARGET_BITS = 8;
   localparam int DIST_BITS   = 48;

   typedef logic [1:0] action_type;
   localparam action_type ACT_LOAD_OFFSET = 2'd0;
   localparam action_type ACT_LOAD_EDGE   = 2'd1;
   localparam action_type ACT_RUN         = 2'd2;
   localparam action_type ACT_READ        = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_INVALID = 2'd1;
   localparam status_type STATUS_RANGE   = 2'd2;

   localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
   localparam logic [1:0] REG_EDGE_COUNT   = 2'd1;
   localparam logic [1:0] REG_SOURCE_INDEX = 2'd2;

endpackage

/* sv/bellman_ford_csr_shortest_paths_unit.sv */
// ----------------------------------------------------------------------------
// Bellman-Ford shortest paths unit over a compressed-row graph
// Loads row offsets and edges, checks and relaxes the graph, reads distances.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel and each gives exactly one response on the
// rsp_ channel. Register writes on the csr_ channel are always taken; the user
// must see that they are made while the unit is idle; the unit does not enforce
// it. A load request's response is registered in the cycle after it is taken. A
// read request answers through the registered distance memory and a wait state.
// A run request first checks each offset and edge, then relaxes the graph round
// by round, visiting every vertex and every edge leaving a reached vertex, all
// through one adder and one comparator that are shared by every edge, with one
// read and one write port on each store. The unit takes no request during a run.
// The response sits in an output register until it is taken; a new request is
// taken while it waits only once it is being taken in the same cycle. Reset
// clears the state, the csr_ registers, the reached flags and the round count;
// the offset and edge stores hold nothing defined until they are loaded.
// ----------------------------------------------------------------------------
module bellman_ford_csr_shortest_paths_unit #(
   parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEFAULT,
   parameter int MAX_EDGES    = bfsp_pkg::MAX_EDGES_DEFAULT,
   parameter int WEIGHT_BITS  = bfsp_pkg::WEIGHT_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_action,
   input  logic [9:0]                        req_slot,
   input  logic [10:0]                       req_row_offset,
   input  logic [7:0]                        req_edge_target,
   input  logic signed [31:0]                req_edge_weight,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic signed [47:0]                rsp_distance,
   output logic                              rsp_reached,
   output logic [7:0]                        rsp_rounds_used,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [10:0]                       csr_data
);

   localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int OAW = $clog2(MAX_VERTICES + 1);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int OB  = bfsp_pkg::OFFSET_BITS;
   localparam int DB  = bfsp_pkg::DIST_BITS;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_RD_WAIT = 4'd1;
   localparam logic [3:0] S_CO_RD   = 4'd2;
   localparam logic [3:0] S_CO_CK   = 4'd3;
   localparam logic [3:0] S_CT_RD   = 4'd4;
   localparam logic [3:0] S_CT_CK   = 4'd5;
   localparam logic [3:0] S_R_INIT  = 4'd6;
   localparam logic [3:0] S_R_ROUND = 4'd7;
   localparam logic [3:0] S_R_VTX   = 4'd8;
   localparam logic [3:0] S_R_OFS0  = 4'd9;
   localparam logic [3:0] S_R_OFS1  = 4'd10;
   localparam logic [3:0] S_R_EDGE  = 4'd11;
   localparam logic [3:0] S_R_TGT   = 4'd12;
   localparam logic [3:0] S_R_DIST  = 4'd13;

   logic [OB-1:0]                 off_mem [MAX_VERTICES+1];
   logic [bfsp_pkg::TARGET_BITS-1:0] tgt_mem [MAX_EDGES];
   logic [WEIGHT_BITS-1:0]        wgt_mem [MAX_EDGES];
   logic signed [DB-1:0]          dist_mem [MAX_VERTICES];

   logic [3:0]  state_ff, state_in;
   logic [8:0]  vc_ff, vc_in;
   logic [10:0] ec_ff, ec_in;
   logic [7:0]  src_ff, src_in;
   logic [7:0]  round_count_ff, round_count_in;
   logic [MAX_VERTICES-1:0] flag_ff, flag_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        changed_ff, changed_in;

   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic signed [DB-1:0] rsp_distance_ff, rsp_distance_in;
   logic                 rsp_reached_ff, rsp_reached_in;
   logic [7:0]           rsp_rounds_ff, rsp_rounds_in;
   logic [OAW-1:0]       vi_ff, vi_in;
   logic [OAW-1:0]       rounds_ff, rounds_in;
   logic [OB-1:0]        e_ff, e_in;
   logic [OB-1:0]        end_ff, end_in;
   logic [OB-1:0]        prev_ff, prev_in;
   logic signed [DB-1:0] du_ff, du_in;
   logic signed [DB-1:0] nd_ff, nd_in;
   logic                 reach_ff, reach_in;

   logic [OB-1:0]                    off_rd_ff;
   logic [bfsp_pkg::TARGET_BITS-1:0] tgt_rd_ff;
   logic signed [WEIGHT_BITS-1:0]    wgt_rd_ff;
   logic signed [DB-1:0]             dist_rd_ff;

   logic                 off_we, edge_we, dist_we;
   logic [OAW-1:0]       off_waddr, off_raddr;
   logic [EAW-1:0]       edge_waddr, edge_raddr;
   logic [VAW-1:0]       dist_waddr, dist_raddr;
   logic signed [DB-1:0] dist_wdata;
   logic [63:0]          w_raw;
   logic [31:0]          slot_w, vi_w, e_w, tgt_w, src_w;
   logic signed [48:0]   w_ext;
   logic signed [49:0]   sum_s;
   logic signed [DB-1:0] sum_sat;
   logic                 accept, go_next, resp_fire, resp_reach;
   logic [1:0]           resp_status;
   logic signed [DB-1:0] resp_dist;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_distance    = rsp_distance_ff;
   assign rsp_reached     = rsp_reached_ff;
   assign rsp_rounds_used = rsp_rounds_ff;

   assign w_raw  = 64'(unsigned'(req_edge_weight));
   assign slot_w = 32'(req_slot);
   assign vi_w   = 32'(vi_ff);
   assign e_w    = 32'(e_ff);
   assign tgt_w  = 32'(tgt_rd_ff);
   assign src_w  = 32'(src_ff);
   assign w_ext  = 49'(wgt_rd_ff);
   assign sum_s  = 50'(du_ff) + 50'(w_ext);

   always_comb begin
      if (sum_s[49:47] == 3'b000 || sum_s[49:47] == 3'b111) begin
         sum_sat = sum_s[DB-1:0];
      end else if (sum_s[49]) begin
         sum_sat = {1'b1, {(DB-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(DB-1){1'b1}}};
      end
   end

   always_comb begin
      state_in = state_ff;
      vc_in = vc_ff;
      ec_in = ec_ff;
      src_in = src_ff;
      round_count_in = round_count_ff;
      flag_in = flag_ff;
      rsp_valid_in = rsp_valid_ff;
      changed_in = changed_ff;
      rsp_status_in = rsp_status_ff;
      rsp_distance_in = rsp_distance_ff;
      rsp_reached_in = rsp_reached_ff;
      rsp_rounds_in = rsp_rounds_ff;
      vi_in = vi_ff;
      rounds_in = rounds_ff;
      e_in = e_ff;
      end_in = end_ff;
      prev_in = prev_ff;
      du_in = du_ff;
      nd_in = nd_ff;
      reach_in = reach_ff;
      off_we = 1'b0;
      edge_we = 1'b0;
      dist_we = 1'b0;
      off_waddr = slot_w[OAW-1:0];
      edge_waddr = slot_w[EAW-1:0];
      dist_waddr = tgt_w[VAW-1:0];
      dist_wdata = nd_ff;
      off_raddr = vi_ff;
      edge_raddr = e_w[EAW-1:0];
      dist_raddr = vi_w[VAW-1:0];
      go_next = 1'b0;
      resp_fire = 1'b0;
      resp_status = bfsp_pkg::STATUS_OK;
      resp_dist = '0;
      resp_reach = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            bfsp_pkg::REG_VERTEX_COUNT: vc_in = csr_data[8:0];
            bfsp_pkg::REG_EDGE_COUNT:   ec_in = csr_data;
            bfsp_pkg::REG_SOURCE_INDEX: src_in = csr_data[7:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  bfsp_pkg::ACT_LOAD_OFFSET: begin
                     resp_fire = 1'b1;
                     if (slot_w <= 32'(MAX_VERTICES)) begin
                        off_we = 1'b1;
                     end else begin
                        resp_status = bfsp_pkg::STATUS_RANGE;
                     end
                  end
                  bfsp_pkg::ACT_LOAD_EDGE: begin
                     resp_fire = 1'b1;
                     if (slot_w < 32'(MAX_EDGES)) begin
                        edge_we = 1'b1;
                     end else begin
                        resp_status = bfsp_pkg::STATUS_RANGE;
                     end
                  end
                  bfsp_pkg::ACT_RUN: begin
                     if (32'(vc_ff) > 32'(MAX_VERTICES) || 32'(ec_ff) > 32'(MAX_EDGES)
                         || (vc_ff == 9'd0 && src_ff != 8'd0)
                         || (vc_ff != 9'd0 && 32'(src_ff) >= 32'(vc_ff))) begin
                        resp_fire = 1'b1;
                        resp_status = bfsp_pkg::STATUS_INVALID;
                     end else begin
                        vi_in = '0;
                        state_in = S_CO_RD;
                     end
                  end
                  bfsp_pkg::ACT_READ: begin
                     if (slot_w < 32'(vc_ff) && slot_w < 32'(MAX_VERTICES)) begin
                        dist_raddr = slot_w[VAW-1:0];
                        reach_in = flag_ff[slot_w[VAW-1:0]];
                        state_in = S_RD_WAIT;
                     end else begin
                        resp_fire = 1'b1;
                        resp_status = bfsp_pkg::STATUS_RANGE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RD_WAIT: begin
            resp_fire = 1'b1;
            resp_reach = reach_ff;
            resp_dist = reach_ff ? dist_rd_ff : '0;
            state_in = S_IDLE;
         end
         S_CO_RD: begin
            off_raddr = vi_ff;
            state_in = S_CO_CK;
         end
         S_CO_CK: begin
            prev_in = off_rd_ff;
            if ((vi_ff == '0 && off_rd_ff != '0) || (vi_ff != '0 && off_rd_ff < prev_ff)
                || (vi_w == 32'(vc_ff) && off_rd_ff != ec_ff)) begin
               resp_fire = 1'b1;
               resp_status = bfsp_pkg::STATUS_INVALID;
               state_in = S_IDLE;
            end else if (vi_w == 32'(vc_ff)) begin
               e_in = '0;
               state_in = (ec_ff == '0) ? S_R_INIT : S_CT_RD;
            end else begin
               vi_in = vi_ff + 1'b1;
               state_in = S_CO_RD;
            end
         end
         S_CT_RD: begin
            edge_raddr = e_w[EAW-1:0];
            state_in = S_CT_CK;
         end
         S_CT_CK: begin
            if (tgt_w >= 32'(vc_ff)) begin
               resp_fire = 1'b1;
               resp_status = bfsp_pkg::STATUS_INVALID;
               state_in = S_IDLE;
            end else if (e_w + 32'd1 == 32'(ec_ff)) begin
               state_in = S_R_INIT;
            end else begin
               e_in = e_ff + 1'b1;
               state_in = S_CT_RD;
            end
         end
         S_R_INIT: begin
            flag_in = '0;
            if (vc_ff != 9'd0) begin
               flag_in[src_w[VAW-1:0]] = 1'b1;
               dist_we = 1'b1;
               dist_waddr = src_w[VAW-1:0];
               dist_wdata = '0;
            end
            rounds_in = '0;
            if (32'(vc_ff) <= 32'd1) begin
               round_count_in = '0;
               resp_fire = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_R_ROUND;
            end
         end
         S_R_ROUND: begin
            rounds_in = rounds_ff + 1'b1;
            changed_in = 1'b0;
            vi_in = '0;
            state_in = S_R_VTX;
         end
         S_R_VTX: begin
            if (flag_ff[vi_w[VAW-1:0]]) begin
               off_raddr = vi_ff;
               dist_raddr = vi_w[VAW-1:0];
               state_in = S_R_OFS0;
            end else begin
               go_next = 1'b1;
            end
         end
         S_R_OFS0: begin
            e_in = off_rd_ff;
            du_in = dist_rd_ff;
            off_raddr = OAW'(vi_w + 32'd1);
            state_in = S_R_OFS1;
         end
         S_R_OFS1: begin
            end_in = off_rd_ff;
            state_in = S_R_EDGE;
         end
         S_R_EDGE: begin
            if (e_ff >= end_ff) begin
               go_next = 1'b1;
            end else begin
               edge_raddr = e_w[EAW-1:0];
               state_in = S_R_TGT;
            end
         end
         S_R_TGT: begin
            dist_raddr = tgt_w[VAW-1:0];
            nd_in = sum_sat;
            state_in = S_R_DIST;
         end
         S_R_DIST: begin
            if (!flag_ff[tgt_w[VAW-1:0]] || nd_ff < dist_rd_ff) begin
               dist_we = 1'b1;
               dist_waddr = tgt_w[VAW-1:0];
               flag_in[tgt_w[VAW-1:0]] = 1'b1;
               changed_in = 1'b1;
               if (tgt_w == vi_w) begin
                  du_in = nd_ff;
               end
            end
            e_in = e_ff + 1'b1;
            state_in = S_R_EDGE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (go_next) begin
         if (vi_w + 32'd1 == 32'(vc_ff)) begin
            if (!changed_ff || 32'(rounds_ff) + 32'd1 == 32'(vc_ff)) begin
               round_count_in = (32'(rounds_ff) > 32'd255) ? 8'd255 : 8'(rounds_ff);
               resp_fire = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_R_ROUND;
            end
         end else begin
            vi_in = vi_ff + 1'b1;
            state_in = S_R_VTX;
         end
      end

      if (resp_fire) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = resp_status;
         rsp_distance_in = resp_dist;
         rsp_reached_in = resp_reach;
         rsp_rounds_in = round_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vc_ff <= '0;
         ec_ff <= '0;
         src_ff <= '0;
         round_count_ff <= '0;
         flag_ff <= '0;
         rsp_valid_ff <= 1'b0;
         changed_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vc_ff <= vc_in;
         ec_ff <= ec_in;
         src_ff <= src_in;
         round_count_ff <= round_count_in;
         flag_ff <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
         changed_ff <= changed_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_distance_ff <= rsp_distance_in;
      rsp_reached_ff <= rsp_reached_in;
      rsp_rounds_ff <= rsp_rounds_in;
      vi_ff <= vi_in;
      rounds_ff <= rounds_in;
      e_ff <= e_in;
      end_ff <= end_in;
      prev_ff <= prev_in;
      du_ff <= du_in;
      nd_ff <= nd_in;
      reach_ff <= reach_in;
   end

   always_ff @(posedge clock) begin
      if (off_we) begin
         off_mem[off_waddr] <= req_row_offset;
      end
      off_rd_ff <= off_mem[off_raddr];
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         tgt_mem[edge_waddr] <= req_edge_target;
         wgt_mem[edge_waddr] <= w_raw[WEIGHT_BITS-1:0];
      end
      tgt_rd_ff <= tgt_mem[edge_raddr];
      wgt_rd_ff <= wgt_mem[edge_raddr];
   end

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_waddr] <= dist_wdata;
      end
      dist_rd_ff <= dist_mem[dist_raddr];
   end

endmodule

/* sv/bfsp_checker.sv */
// ----------------------------------------------------------------------------
// Shortest paths unit checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "bellman_ford_csr_shortest_paths_unit_assert.svh"

module bfsp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_action,
   input logic [9:0]         req_slot,
   input logic [10:0]        req_row_offset,
   input logic [7:0]         req_edge_target,
   input logic signed [31:0] req_edge_weight,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic signed [47:0] rsp_distance,
   input logic               rsp_reached,
   input logic [7:0]         rsp_rounds_used,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic [1:0]         csr_index,
   input logic [10:0]        csr_data
);

   `BFSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_distance))
   `BFSP_ASSERT_SAME(a_unreached_zero, clock, reset, rsp_valid && !rsp_reached,
      rsp_distance == 48'sd0)
   `BFSP_ASSERT_SAME(a_fail_no_data, clock, reset,
      rsp_valid && rsp_status != bfsp_pkg::STATUS_OK, !rsp_reached)
   `BFSP_ASSERT_SAME(a_status_code, clock, reset, rsp_valid,
      rsp_status == bfsp_pkg::STATUS_OK || rsp_status == bfsp_pkg::STATUS_INVALID
      || rsp_status == bfsp_pkg::STATUS_RANGE)

endmodule

bind bellman_ford_csr_shortest_paths_unit bfsp_checker u_bfsp_checker (.*);
